>>> rtl/lrl_pkg.sv
// lrl_pkg: shared constants for the LRU recency list.
// Default sizes and the fixed stream field widths. No dependencies.
`timescale 1ns / 1ps

package lrl_pkg;

  localparam int unsigned LrlDepth     = 8;
  localparam int unsigned LrlKeyWidth  = 32;

  // fixed widths of the stream fields
  localparam int unsigned InKeyW       = 32;
  localparam int unsigned OutPosW      = 3;
  localparam int unsigned OutKeyW      = 32;
  localparam int unsigned CapW         = 4;
  localparam int unsigned OutPayloadW  = 1 + OutPosW + 1 + OutKeyW;
  localparam int unsigned OutTdataW    = ((OutPayloadW + 7) / 8) * 8;

endpackage

>>> rtl/lrl_ram.sv
// lrl_ram: generic single-write, single-read synchronous RAM.
// Read data registered. No dependencies.
`timescale 1ns / 1ps

module lrl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lru_recency_list.sv
// lru_recency_list: move-to-front recency list of keys in one RAM; needs lrl_pkg, lrl_ram.
// One entry is scanned per cycle, from the front up to a hit or past the last valid entry;
// the result is registered once the last scan step finds the output register free.
// A new key is taken only while idle; a result still held stretches the last scan.
// Reset clears fill count, state and output valid; capacity resets to 8. RAM contents
// are left as they are, only entries below the fill count are used.
`timescale 1ns / 1ps

module lru_recency_list
  import lrl_pkg::*;
#(
  parameter int unsigned DEPTH     = LrlDepth,
  parameter int unsigned KEY_WIDTH = LrlKeyWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration: capacity register
  input  logic                 cfg_we_i,
  input  logic [CapW-1:0]      cfg_wdata_i,
  // input stream
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [InKeyW-1:0]    s_tdata_i,   // [31:0] key
  // result stream
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [OutTdataW-1:0] m_tdata_o    // [0] hit, [3:1] hit_position,
                                            // [4] evicted, [36:5] evicted_key,
                                            // [39:37] zero
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);   // counts 0..DEPTH
  localparam int unsigned CmpW = (CW > CapW) ? CW : CapW;

  typedef enum logic {
    StIdle,
    StScan
  } state_e;

  state_e               state_q, state_d;
  logic [CapW-1:0]      cap_q, cap_d;
  logic [CW-1:0]        fill_q, fill_d;
  logic [CW-1:0]        lim_q, lim_d;       // valid entries for this key
  logic [CW-1:0]        capx_q, capx_d;     // effective capacity for this key
  logic [CW-1:0]        idx_q, idx_d;       // entry whose read data arrives now
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [KEY_WIDTH-1:0] carry_q, carry_d;   // entry one place in front of idx

  logic                 ov_q, ov_d;
  logic                 hit_q, hit_d;
  logic [OutPosW-1:0]   pos_q, pos_d;
  logic                 ev_q, ev_d;
  logic [OutKeyW-1:0]   evkey_q, evkey_d;

  // RAM port signals
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [KEY_WIDTH-1:0] rdata;

  // capacity as used: zero reads as one, above DEPTH saturates
  function automatic logic [CW-1:0] eff_cap(input logic [CapW-1:0] c);
    logic [CmpW-1:0] cx;
    cx = CmpW'(c);
    if (cx == '0) begin
      return CW'(1);
    end else if (cx > CmpW'(DEPTH)) begin
      return CW'(DEPTH);
    end
    return CW'(cx);
  endfunction

  lrl_ram #(
    .Width (KEY_WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (carry_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign s_tready_o = (state_q == StIdle);
  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = OutTdataW'({evkey_q, ev_q, pos_q, hit_q});

  logic       out_free;
  logic       at_end;
  logic       found;
  logic [CW-1:0] ecap_new;

  // the scan keeps the read of idx+1 in flight; on the last step idx is read again so
  // the data still stands if the result has to wait; idle primes entry 0
  assign raddr = (state_q == StIdle) ? '0 :
                 (at_end || found)   ? AW'(idx_q) : AW'(idx_q + CW'(1));
  assign waddr = AW'(idx_q);

  always_comb begin
    state_d = state_q;
    cap_d   = cap_q;
    fill_d  = fill_q;
    lim_d   = lim_q;
    capx_d  = capx_q;
    idx_d   = idx_q;
    key_d   = key_q;
    carry_d = carry_q;
    ov_d    = ov_q;
    hit_d   = hit_q;
    pos_d   = pos_q;
    ev_d    = ev_q;
    evkey_d = evkey_q;
    we      = 1'b0;

    out_free = !ov_q || m_tready_i;
    at_end   = (idx_q == lim_q);
    found    = !at_end && (rdata == key_q);
    ecap_new = eff_cap(cfg_wdata_i);

    if (ov_q && m_tready_i) begin
      ov_d = 1'b0;
    end

    // user sends configuration only when idle, unchecked; lower capacity drops the tail
    if (cfg_we_i) begin
      cap_d = cfg_wdata_i;
      if (fill_q > ecap_new) begin
        fill_d = ecap_new;
      end
    end

    case (state_q)
      StIdle: begin
        if (s_tvalid_i) begin
          key_d   = KEY_WIDTH'(s_tdata_i);
          carry_d = KEY_WIDTH'(s_tdata_i);
          capx_d  = eff_cap(cap_q);
          lim_d   = (fill_q > eff_cap(cap_q)) ? eff_cap(cap_q) : fill_q;
          idx_d   = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        if (at_end || found) begin
          // last step: needs a free output register
          if (out_free) begin
            ov_d    = 1'b1;
            hit_d   = found;
            pos_d   = found ? OutPosW'(idx_q) : '0;
            ev_d    = 1'b0;
            evkey_d = '0;
            state_d = StIdle;
            if (found) begin
              we     = 1'b1;
              fill_d = lim_q;
            end else if (lim_q == capx_q) begin
              // full miss: the tail fell out into the carry
              ev_d    = 1'b1;
              evkey_d = OutKeyW'(carry_q);
              fill_d  = lim_q;
            end else begin
              we     = 1'b1;
              fill_d = lim_q + CW'(1);
            end
          end
        end else begin
          // shift back one place and keep searching
          we      = 1'b1;
          carry_d = rdata;
          idx_d   = idx_q + CW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cap_q   <= CapW'(8);
      fill_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cap_q   <= cap_d;
      fill_q  <= fill_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q   <= lim_d;
    capx_q  <= capx_d;
    idx_q   <= idx_d;
    key_q   <= key_d;
    carry_q <= carry_d;
    hit_q   <= hit_d;
    pos_q   <= pos_d;
    ev_q    <= ev_d;
    evkey_q <= evkey_d;
  end

endmodule

>>> tb/tb.sv
// tb: self-checking bench for lru_recency_list (move-to-front key list).
// Uses lrl_pkg for stream widths; drives random keys and capacity settings,
// and checks every result transfer against an in-bench recency mirror.
`timescale 1ns / 1ps

module tb;
  import lrl_pkg::*;

  localparam int unsigned StuckLimit = 1000;  // cycles without any transfer
  localparam int unsigned DrainWait  = LrlDepth + 6;

  // expected fields of one result transfer
  typedef struct packed {
    logic                 hit;
    logic [OutPosW-1:0]   hit_position;
    logic                 evicted;
    logic [OutKeyW-1:0]   evicted_key;
  } lru_result_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [CapW-1:0]      cfg_wdata   = '0;
  logic                 s_tvalid    = 1'b0;
  logic                 s_tready_o;
  logic [InKeyW-1:0]    s_tdata     = '0;
  logic                 m_tvalid_o;
  logic                 m_tready    = 1'b0;
  logic [OutTdataW-1:0] m_tdata_o;

  // keys waiting to be offered, and results still owed by the block
  logic [InKeyW-1:0] key_q[$];
  lru_result_t       result_q[$];

  // recency mirror
  logic [LrlKeyWidth-1:0] mirror_keys[LrlDepth];
  int unsigned            mirror_fill = 0;
  logic [CapW-1:0]        mirror_cap  = CapW'(8);

  int unsigned n_queued   = 0;
  int unsigned n_results  = 0;
  int unsigned n_fail     = 0;
  int unsigned idle_pct   = 0;
  int unsigned key_gap    = 0;
  int unsigned res_stall  = 0;
  int unsigned stuck_cnt  = 0;

  lru_recency_list uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // zero reads as one, anything past the depth saturates
  function automatic int unsigned eff_capacity(input logic [CapW-1:0] cap);
    int unsigned c;
    c = cap;
    if (c == 0) c = 1;
    if (c > LrlDepth) c = LrlDepth;
    return c;
  endfunction

  // one access on the mirror: search, move to front, report
  function automatic lru_result_t lru_access(input logic [InKeyW-1:0] key);
    lru_result_t r;
    int unsigned cap;
    int unsigned pos;
    int unsigned shift_end;
    bit          found;
    r     = '0;
    cap   = eff_capacity(mirror_cap);
    pos   = 0;
    found = 1'b0;
    if (mirror_fill > cap) mirror_fill = cap;
    for (int unsigned i = 0; i < mirror_fill; i++) begin
      if (!found && mirror_keys[i] == key) begin
        found = 1'b1;
        pos   = i;
      end
    end
    if (found) begin
      shift_end = pos;
    end else begin
      if (mirror_fill >= cap) begin
        r.evicted     = 1'b1;
        r.evicted_key = mirror_keys[cap-1];
        mirror_fill   = cap - 1;
      end
      shift_end   = mirror_fill;
      mirror_fill = mirror_fill + 1;
    end
    for (int unsigned i = shift_end; i > 0; i--) mirror_keys[i] = mirror_keys[i-1];
    mirror_keys[0] = key;
    r.hit          = found;
    r.hit_position = OutPosW'(pos);
    return r;
  endfunction

  // driver: one key per transfer, random gaps between transfers
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      key_gap  <= 0;
    end else begin
      if (s_tvalid && s_tready_o) result_q.push_back(lru_access(s_tdata));
      if (!s_tvalid || s_tready_o) begin
        if (key_gap > 0) begin
          key_gap  <= key_gap - 1;
          s_tvalid <= 1'b0;
        end else if (key_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= key_q.pop_front();
          if ($urandom_range(0, 99) < idle_pct) key_gap <= $urandom_range(1, 17);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, field-by-field compare
  always @(posedge clk_i or negedge rst_n) begin
    lru_result_t exp_r;
    if (!rst_n) begin
      m_tready  <= 1'b0;
      res_stall <= 0;
    end else begin
      if (m_tvalid_o && m_tready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result transfer, tdata %h", m_tdata_o);
          n_fail++;
        end else begin
          exp_r = result_q.pop_front();
          n_results++;
          if (m_tdata_o[0] !== exp_r.hit) begin
            $error("hit: expected %0d, got %0d", exp_r.hit, m_tdata_o[0]);
            n_fail++;
          end
          if (m_tdata_o[3:1] !== exp_r.hit_position) begin
            $error("hit_position: expected %0d, got %0d", exp_r.hit_position,
                   m_tdata_o[3:1]);
            n_fail++;
          end
          if (m_tdata_o[4] !== exp_r.evicted) begin
            $error("evicted: expected %0d, got %0d", exp_r.evicted, m_tdata_o[4]);
            n_fail++;
          end
          if (m_tdata_o[36:5] !== exp_r.evicted_key) begin
            $error("evicted_key: expected %h, got %h", exp_r.evicted_key,
                   m_tdata_o[36:5]);
            n_fail++;
          end
          if (m_tdata_o[OutTdataW-1:37] !== '0) begin
            $error("padding: expected 0, got %h", m_tdata_o[OutTdataW-1:37]);
            n_fail++;
          end
        end
      end
      if (res_stall > 0) begin
        res_stall <= res_stall - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 99) < idle_pct) res_stall <= $urandom_range(1, 17);
      end
    end
  end

  // watchdog: too long without any transfer means the block is stuck
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready_o) || (m_tvalid_o && m_tready) || cfg_we || !rst_n) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= StuckLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  task automatic add_key(input logic [InKeyW-1:0] key);
    key_q.push_back(key);
    n_queued++;
  endtask

  // wait until every queued key has produced its result, then a few cycles more
  task automatic wait_idle();
    while (n_results != n_queued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] cap);
    wait_idle();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    // register taken at this edge; mirror follows, truncating silently
    mirror_cap = cap;
    if (mirror_fill > eff_capacity(cap)) mirror_fill = eff_capacity(cap);
  endtask

  // random phase: mostly keys from a small pool so hits and evictions mix
  task automatic random_phase(input logic [CapW-1:0] cap, input int unsigned n_keys,
                              input int unsigned idle);
    logic [InKeyW-1:0] pool[$];
    logic [InKeyW-1:0] key;
    logic [InKeyW-1:0] prev;
    int unsigned       pool_size;
    int unsigned       pick;
    write_capacity(cap);
    idle_pct  = idle;
    pool_size = eff_capacity(cap) + $urandom_range(0, 3);
    for (int unsigned i = 0; i < pool_size; i++) pool.push_back($urandom());
    prev = pool[0];
    for (int unsigned i = 0; i < n_keys; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) key = pool[$urandom_range(0, pool_size - 1)];
      else if (pick < 75) key = prev;                                   // front hit
      else if (pick < 83) key = $urandom();
      else if (pick < 90) key = pool[$urandom_range(0, pool_size - 1)]
                                ^ (32'h1 << $urandom_range(0, 31));    // near miss
      else if (pick < 95) key = $urandom_range(0, 1) ? '0 : '1;
      else key = $urandom_range(0, 1) ? (32'h1 << $urandom_range(0, 31))
                                      : ~(32'h1 << $urandom_range(0, 31));
      add_key(key);
      prev = key;
    end
  endtask

  initial begin
    for (int unsigned i = 0; i < LrlDepth; i++) mirror_keys[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed, reset capacity of eight
    add_key(32'h0000_0000);
    add_key(32'hFFFF_FFFF);
    add_key(32'h0000_0000);        // hit one place back
    add_key(32'h0000_0000);        // hit at the front
    for (int unsigned k = 1; k <= 6; k++) add_key(k);   // list now full
    add_key(32'hFFFF_FFFF);        // hit at the tail
    add_key(32'h0000_0000);        // tail again
    add_key(32'h8000_0000);        // miss on a full list, tail evicted
    add_key(32'h5555_5555);
    add_key(32'hAAAA_AAAA);

    // lowering capacity drops tail entries without reporting them
    write_capacity(CapW'(3));
    add_key(32'hAAAA_AAAA);        // hit at the front
    add_key(32'h0000_1234);        // miss, evicts position two
    add_key(32'h0000_0006);        // key that was dropped: a miss, evicts the tail
    write_capacity(CapW'(0));      // zero behaves as one
    add_key(32'h0000_0006);
    add_key(32'h7FFF_FFFF);
    write_capacity(CapW'(15));     // saturates at the depth
    add_key(32'h0000_0006);
    add_key(32'h7FFF_FFFF);

    random_phase(CapW'(8),  85, 30);
    random_phase(CapW'(3),  85, 0);
    random_phase(CapW'(0),  60, 40);
    random_phase(CapW'(15), 85, 15);
    random_phase(CapW'(1),  60, 25);
    random_phase(CapW'(5),  85, 50);
    random_phase(CapW'(2),  70, 10);
    random_phase(CapW'(12), 85, 35);
    random_phase(CapW'(7),  85, 0);
    random_phase(CapW'(4),  85, 20);
    random_phase(CapW'(6),  85, 30);
    random_phase(CapW'(8),  160, 0);   // closing stretch without idling

    while (n_results != n_queued) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (n_fail == 0 && result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (result_q.size() != 0) $error("%0d results never arrived", result_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
